### rtl/msp_pkg.sv
package msp_pkg;

  // Payload widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned SIDX_W  = 4;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 4;

  // Operation codes; code three acts as a peek
  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_STACK = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  localparam logic [DATA_W-1:0] ERR_VALUE = '1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

  // Sequencer states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

endpackage

### rtl/multi_stack_shared_pool.sv
// Channel   Direction  Handshake              Payload
// request   in         in_valid_i/in_ready_o   mode_i, stack_index_i, push_value_i
// result    out        out_valid_o/out_ready_i read_value_o, status_o
// config    in         cfg_we_i (no wait)      cfg_data_i (stack count)
//
// Each request has an accept step and an execute step: accept reads the node
// memory at the stack top (pop, peek) or the free-list head (push); execute
// updates pointers, writes the node back and loads the result register.
// A result waiting in the output register holds the execute cycle, so a full
// output plus a stalled consumer stops the next request after its accept.
// Reset clears top valid bits, free list and fresh count; node memory is not
// cleared.
module multi_stack_shared_pool #(
  parameter int unsigned MAX_STACKS = 8,
  parameter int unsigned POOL_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [msp_pkg::COUNT_W-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [msp_pkg::MODE_W-1:0]          mode_i,
  input  logic [msp_pkg::SIDX_W-1:0]          stack_index_i,
  input  logic signed [msp_pkg::DATA_W-1:0]   push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [msp_pkg::DATA_W-1:0]   read_value_o,
  output logic [msp_pkg::STAT_W-1:0]          status_o
);

  localparam int unsigned AW = $clog2(POOL_DEPTH);
  localparam int unsigned SW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int unsigned DW = msp_pkg::DATA_W;
  localparam int unsigned NW = DW + AW + 1;
  localparam int unsigned CW = msp_pkg::SIDX_W + 1;
  localparam logic [AW:0]   POOL_FULL = (AW + 1)'(POOL_DEPTH);
  localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_STACKS);

  msp_pkg::state_e state_q, state_d;

  logic [msp_pkg::COUNT_W-1:0] count_q;

  logic [AW-1:0] top_q [MAX_STACKS];
  logic [AW-1:0] top_d [MAX_STACKS];
  logic          tv_q  [MAX_STACKS];
  logic          tv_d  [MAX_STACKS];

  logic [AW-1:0] free_head_q, free_head_d;
  logic          free_valid_q, free_valid_d;
  logic [AW:0]   fresh_q, fresh_d;

  // latched request
  logic [msp_pkg::MODE_W-1:0] req_mode_q;
  logic [msp_pkg::SIDX_W-1:0] req_sidx_q;
  logic [DW-1:0]              req_val_q;

  // result register
  logic                        out_valid_q, out_valid_d;
  logic [DW-1:0]               out_value_q, res_value;
  logic [msp_pkg::STAT_W-1:0]  out_status_q, res_status;

  // memory ports
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [NW-1:0] mem_wdata, mem_rdata;
  logic [DW-1:0] rd_value;
  logic [AW-1:0] rd_link;
  logic          rd_lv;

  logic          accept, fire, bad_stack, fresh_avail;
  logic [CW-1:0] active_cnt;
  logic [SW-1:0] sidx;
  logic [AW-1:0] cur_top, new_node;
  logic          cur_tv;

  msp_ram #(
    .WIDTH(NW),
    .DEPTH(POOL_DEPTH)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign rd_value = mem_rdata[DW-1:0];
  assign rd_link  = mem_rdata[DW+AW-1:DW];
  assign rd_lv    = mem_rdata[NW-1];

  // handshakes
  assign in_ready_o = (state_q == msp_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign fire       = (state_q == msp_pkg::S_EXEC) && (!out_valid_q || out_ready_i);

  // read issue at accept: free-list head for push, stack top otherwise
  assign mem_re    = accept;
  assign mem_raddr = (mode_i == msp_pkg::MODE_PUSH) ? free_head_q
                                                    : top_q[stack_index_i[SW-1:0]];

  // stack number check, count saturates at MAX_STACKS
  assign active_cnt = ({1'b0, count_q} > MAX_CNT) ? MAX_CNT : CW'(count_q);
  assign bad_stack  = ({1'b0, req_sidx_q} >= active_cnt);
  assign sidx       = req_sidx_q[SW-1:0];
  assign cur_top    = top_q[sidx];
  assign cur_tv     = tv_q[sidx];

  assign fresh_avail = (fresh_q < POOL_FULL);
  assign new_node    = free_valid_q ? free_head_q : fresh_q[AW-1:0];

  // execute: result, pointer updates and node write-back
  always_comb begin
    top_d        = top_q;
    tv_d         = tv_q;
    free_head_d  = free_head_q;
    free_valid_d = free_valid_q;
    fresh_d      = fresh_q;
    mem_we       = 1'b0;
    mem_waddr    = cur_top;
    mem_wdata    = {free_valid_q, free_head_q, rd_value};
    res_value    = msp_pkg::ERR_VALUE;
    res_status   = msp_pkg::ST_OK;

    priority if (bad_stack) begin
      res_status = msp_pkg::ST_BAD_STACK;
    end else if (req_mode_q == msp_pkg::MODE_PUSH) begin
      if (free_valid_q || fresh_avail) begin
        res_value   = '0;
        mem_we      = fire;
        mem_waddr   = new_node;
        mem_wdata   = {cur_tv, cur_top, req_val_q};
        if (fire) begin
          top_d[sidx] = new_node;
          tv_d[sidx]  = 1'b1;
          if (free_valid_q) begin
            free_head_d  = rd_link;
            free_valid_d = rd_lv;
          end else begin
            fresh_d = fresh_q + 1'b1;
          end
        end
      end else begin
        res_status = msp_pkg::ST_FULL;
      end
    end else if (!cur_tv) begin
      res_status = msp_pkg::ST_EMPTY;
    end else begin
      res_value = rd_value;
      if (req_mode_q == msp_pkg::MODE_POP) begin
        // unlink top, put node at the free-list head
        mem_we = fire;
        if (fire) begin
          top_d[sidx]  = rd_link;
          tv_d[sidx]   = rd_lv;
          free_head_d  = cur_top;
          free_valid_d = 1'b1;
        end
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      msp_pkg::S_IDLE: begin
        if (accept) begin
          state_d = msp_pkg::S_EXEC;
        end
      end
      msp_pkg::S_EXEC: begin
        if (fire) begin
          state_d = msp_pkg::S_IDLE;
        end
      end
      default: state_d = msp_pkg::S_IDLE;
    endcase
  end

  assign out_valid_d = fire || (out_valid_q && !out_ready_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= msp_pkg::S_IDLE;
      count_q      <= msp_pkg::COUNT_RESET;
      free_valid_q <= 1'b0;
      free_head_q  <= '0;
      fresh_q      <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < MAX_STACKS; i++) begin
        tv_q[i] <= 1'b0;
      end
    end else begin
      state_q      <= state_d;
      free_valid_q <= free_valid_d;
      free_head_q  <= free_head_d;
      fresh_q      <= fresh_d;
      out_valid_q  <= out_valid_d;
      tv_q         <= tv_d;
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (accept) begin
      req_mode_q <= mode_i;
      req_sidx_q <= stack_index_i;
      req_val_q  <= push_value_i;
    end
    if (fire) begin
      out_value_q  <= res_value;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign status_o     = out_status_q;

  // checks
  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= POOL_FULL)
    else $error("fresh count beyond pool depth");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == msp_pkg::S_EXEC)
    else $error("accepted request did not enter execute");

  a_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> fire)
    else $error("node write outside execute");

  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != msp_pkg::ST_OK |-> read_value_o == msp_pkg::ERR_VALUE)
    else $error("error result without -1 value");

  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_status == msp_pkg::ST_FULL |-> !free_valid_q && fresh_q == POOL_FULL)
    else $error("pool full reported with free nodes left");

endmodule

### rtl/msp_ram.sv
module msp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port; read data holds without re_i
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
